// File: design/fpw_pkg.sv
// Shared types and constants of the flow partition weighting block.
`default_nettype none
package fpw_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned UFIELD_W = 31;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned NUM_W    = 4;

  localparam logic [30:0] SAT31   = 31'h7FFF_FFFF;
  localparam logic [63:0] RUN_MIN = 64'd655;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // Slope mode codes.
  localparam logic [1:0] MODE_SUM      = 2'd0;
  localparam logic [1:0] MODE_INTERNAL = 2'd1;
  localparam logic [1:0] MODE_MAXIMUM  = 2'd2;
  // Unused code, behaves as summed weights.
  localparam logic [1:0] MODE_SPARE    = 2'd3;

  // Configuration register indexes.
  localparam logic REG_CELL_SIZE  = 1'b0;
  localparam logic REG_SLOPE_MODE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_ROOT,
    S_RUN,
    S_RUNFIX,
    S_SDIV,
    S_SLOPE,
    S_PMUL,
    S_PSLO,
    S_PSHI,
    S_WDIV,
    S_WEIGHT,
    S_SWMUL,
    S_STORE,
    S_FIN,
    S_PDIV,
    S_PSET,
    S_MLO,
    S_MHI,
    S_RD,
    S_RDW,
    S_FDIV,
    S_EMIT
  } fpw_state_t;

endpackage
`default_nettype wire

// File: design/fpw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module fpw_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: design/flow_partition_weights.sv
// Top level of the multiple flow direction weighting block.
`default_nettype none
// Neighbours of one patch arrive one request at a time; each is turned into a slope
// and a flow weight that go to a neighbour RAM, while the weight sum and the
// slope-weighted sum build up in registers. The request marked tlast closes the
// patch: the block then sends one result per stored neighbour with its slope, its
// weight fraction, the weight-averaged patch slope and the total weight. All
// arithmetic runs on one shared radix-2 divider, a one-bit-per-cycle square root and
// multipliers of at most 32 by 32 bits. A neighbour with a positive slope also needs
// the weight product and, unless it saturates, the weight division; each result needs
// a RAM read plus, when the weight sum is not zero, one division. in_tready is high
// only between neighbours; a finished result waits in the output register while the
// next patch starts.
module flow_partition_weights #(
  parameter int MAX_NEIGHBOURS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // delta_x[31:0], delta_y[63:32], rise[95:64], perimeter[126:96],
  // patch_mult[157:127], patch_area[188:158], internal_tan[219:189],
  // max_tan[250:220], zero fill [255:251]
  input  wire logic [255:0] in_tdata,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // neighbour_number[3:0], neighbour_slope[35:4], weight_fraction[52:36],
  // patch_slope[84:53], total_weight[115:85], zero fill [119:116]
  output logic [119:0]      out_tdata,
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [30:0]  cfg_data
);

  localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int ADDR_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int RAM_W  = 63;

  fpw_pkg::fpw_state_t state_r, state_nxt;

  logic [30:0] cell_r, cell_nxt;
  logic [1:0]  mode_r, mode_nxt;

  logic [31:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [31:0] rise_r, rise_nxt;
  logic [30:0] perim_r, perim_nxt, mult_r, mult_nxt, area_r, area_nxt;
  logic [30:0] itan_r, itan_nxt, mtan_r, mtan_nxt;
  logic        last_r, last_nxt;

  logic [63:0] prod_r, prod_nxt;
  logic [63:0] sqv_r, sqv_nxt, sqr_r, sqr_nxt, sqbit_r, sqbit_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt, den_r, den_nxt;
  logic [5:0]  step_r, step_nxt;

  logic [31:0] slope_r, slope_nxt;
  logic [30:0] wgt_r, wgt_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [39:0] ws_r, ws_nxt;
  logic [63:0] sws_r, sws_nxt;
  logic [30:0] pslope_r, pslope_nxt, total_r, total_nxt;
  logic [63:0] macc_r, macc_nxt;
  logic [1:0]  mstep_r, mstep_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;

  logic        out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [3:0]  out_num_r, out_num_nxt;
  logic [31:0] out_slope_r, out_slope_nxt, out_pslope_r, out_pslope_nxt;
  logic [16:0] out_frac_r, out_frac_nxt;
  logic [30:0] out_total_r, out_total_nxt;

  // Shared datapath pieces.
  logic [31:0] in_dx_mag, in_dy_mag, rise_mag;
  logic [64:0] div_shift;
  logic        div_ge;
  logic [63:0] sq_test;
  logic        sq_ge;
  logic        div_last, root_last;
  logic        cnt_full, emit_go, emit_last, slope_pos;
  logic [44:0] ps_hi;
  logic [77:0] ps_full;
  logic [30:0] mul_b;
  logic [62:0] m_hi;
  logic [95:0] m_full;
  logic [63:0] m_res;
  logic        ram_we;
  logic [RAM_W-1:0] ram_q;

  assign in_dx_mag = in_tdata[31] ? (~in_tdata[31:0] + 32'd1) : in_tdata[31:0];
  assign in_dy_mag = in_tdata[63] ? (~in_tdata[63:32] + 32'd1) : in_tdata[63:32];
  assign rise_mag  = rise_r[31] ? (~rise_r + 32'd1) : rise_r;

  assign div_shift = {rem_r[63:0], quo_r[63]};
  assign div_ge    = div_shift >= {1'b0, den_r};
  assign sq_test   = sqr_r + sqbit_r;
  assign sq_ge     = sqv_r >= sq_test;
  assign div_last  = step_r == 6'd63;
  assign root_last = step_r == 6'd31;
  assign cnt_full  = cnt_r == CNT_W'(MAX_NEIGHBOURS);
  assign emit_go   = !out_valid_r || out_tready;
  assign emit_last = (CNT_W'(k_r) + CNT_W'(1)) == cnt_r;
  assign slope_pos = !rise_r[31] && (quo_r != 64'd0);

  // Weight product p*s: high part of p times s, shifted, plus the low partial product.
  assign ps_hi   = 45'(64'(sqr_r[13:0]) * 64'(slope_r[30:0]));
  assign ps_full = {1'b0, ps_hi, 32'd0} + 78'(prod_r);

  always_comb begin
    unique case (mstep_r)
      2'd0:    mul_b = (mode_r == fpw_pkg::MODE_INTERNAL) ? itan_r : mtan_r;
      2'd1:    mul_b = area_r;
      default: mul_b = cell_r;
    endcase
  end

  assign m_hi   = 63'(64'(macc_r[63:32]) * 64'(mul_b));
  assign m_full = {1'b0, m_hi, 32'd0};

  always_comb begin
    logic [95:0] sum;
    sum = m_full + 96'(prod_r);
    if (macc_r == 64'd0 || mul_b == 31'd0) begin
      m_res = 64'd0;
    end else if (macc_r == fpw_pkg::U64_MAX || sum[95:64] != 32'd0) begin
      m_res = fpw_pkg::U64_MAX;
    end else begin
      m_res = {16'd0, sum[63:16]};
    end
  end

  fpw_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_NEIGHBOURS)
  ) u_nbr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata ({slope_r, wgt_r}),
    .raddr (k_r),
    .rdata (ram_q)
  );

  assign ram_we = state_r == fpw_pkg::S_STORE;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpw_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (!cnt_full) state_nxt = fpw_pkg::S_SQX;
          else if (in_tlast) state_nxt = fpw_pkg::S_FIN;
        end
      end
      fpw_pkg::S_SQX:    state_nxt = fpw_pkg::S_SQY;
      fpw_pkg::S_SQY:    state_nxt = fpw_pkg::S_ROOT;
      fpw_pkg::S_ROOT:   if (root_last) state_nxt = fpw_pkg::S_RUN;
      fpw_pkg::S_RUN:    state_nxt = fpw_pkg::S_RUNFIX;
      fpw_pkg::S_RUNFIX: state_nxt = fpw_pkg::S_SDIV;
      fpw_pkg::S_SDIV:   if (div_last) state_nxt = fpw_pkg::S_SLOPE;
      fpw_pkg::S_SLOPE:  state_nxt = slope_pos ? fpw_pkg::S_PMUL : fpw_pkg::S_STORE;
      fpw_pkg::S_PMUL:   state_nxt = fpw_pkg::S_PSLO;
      fpw_pkg::S_PSLO:   state_nxt = fpw_pkg::S_PSHI;
      fpw_pkg::S_PSHI: begin
        state_nxt = (ps_full[77:62] != 16'd0) ? fpw_pkg::S_SWMUL : fpw_pkg::S_WDIV;
      end
      fpw_pkg::S_WDIV:   if (div_last) state_nxt = fpw_pkg::S_WEIGHT;
      fpw_pkg::S_WEIGHT: state_nxt = fpw_pkg::S_SWMUL;
      fpw_pkg::S_SWMUL:  state_nxt = fpw_pkg::S_STORE;
      fpw_pkg::S_STORE:  state_nxt = last_r ? fpw_pkg::S_FIN : fpw_pkg::S_IDLE;
      fpw_pkg::S_FIN:    state_nxt = (ws_r != 40'd0) ? fpw_pkg::S_PDIV : fpw_pkg::S_PSET;
      fpw_pkg::S_PDIV:   if (div_last) state_nxt = fpw_pkg::S_PSET;
      fpw_pkg::S_PSET: begin
        if (mode_r == fpw_pkg::MODE_INTERNAL || mode_r == fpw_pkg::MODE_MAXIMUM) begin
          state_nxt = fpw_pkg::S_MLO;
        end else begin
          state_nxt = fpw_pkg::S_RD;
        end
      end
      fpw_pkg::S_MLO:    state_nxt = fpw_pkg::S_MHI;
      fpw_pkg::S_MHI:    state_nxt = (mstep_r == 2'd3) ? fpw_pkg::S_RD : fpw_pkg::S_MLO;
      fpw_pkg::S_RD:     state_nxt = fpw_pkg::S_RDW;
      fpw_pkg::S_RDW:    state_nxt = (ws_r != 40'd0) ? fpw_pkg::S_FDIV : fpw_pkg::S_EMIT;
      fpw_pkg::S_FDIV:   if (div_last) state_nxt = fpw_pkg::S_EMIT;
      fpw_pkg::S_EMIT: begin
        if (emit_go) state_nxt = emit_last ? fpw_pkg::S_IDLE : fpw_pkg::S_RD;
      end
      default:           state_nxt = fpw_pkg::S_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    cell_nxt = cell_r;       mode_nxt = mode_r;
    dx_nxt = dx_r;           dy_nxt = dy_r;         rise_nxt = rise_r;
    perim_nxt = perim_r;     mult_nxt = mult_r;     area_nxt = area_r;
    itan_nxt = itan_r;       mtan_nxt = mtan_r;     last_nxt = last_r;
    prod_nxt = prod_r;
    sqv_nxt = sqv_r;         sqr_nxt = sqr_r;       sqbit_nxt = sqbit_r;
    rem_nxt = rem_r;         quo_nxt = quo_r;       den_nxt = den_r;
    step_nxt = step_r;
    slope_nxt = slope_r;     wgt_nxt = wgt_r;
    cnt_nxt = cnt_r;         ws_nxt = ws_r;         sws_nxt = sws_r;
    pslope_nxt = pslope_r;   total_nxt = total_r;
    macc_nxt = macc_r;       mstep_nxt = mstep_r;   k_nxt = k_r;
    out_valid_nxt = out_valid_r;  out_last_nxt = out_last_r;
    out_num_nxt = out_num_r;      out_slope_nxt = out_slope_r;
    out_frac_nxt = out_frac_r;    out_pslope_nxt = out_pslope_r;
    out_total_nxt = out_total_r;

    if (cfg_we) begin
      unique case (cfg_index)
        fpw_pkg::REG_CELL_SIZE:  cell_nxt = cfg_data;
        fpw_pkg::REG_SLOPE_MODE: mode_nxt = cfg_data[1:0];
        default:                 mode_nxt = mode_r;
      endcase
    end

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    // Shared divider step, used by all division states.
    if (state_r == fpw_pkg::S_SDIV || state_r == fpw_pkg::S_WDIV ||
        state_r == fpw_pkg::S_PDIV || state_r == fpw_pkg::S_FDIV) begin
      quo_nxt  = {quo_r[62:0], div_ge};
      rem_nxt  = div_ge ? (div_shift - {1'b0, den_r}) : div_shift;
      step_nxt = step_r + 6'd1;
    end

    unique case (state_r)
      fpw_pkg::S_IDLE: begin
        if (in_tvalid) begin
          dx_nxt    = in_dx_mag;
          dy_nxt    = in_dy_mag;
          rise_nxt  = in_tdata[95:64];
          perim_nxt = in_tdata[126:96];
          mult_nxt  = in_tdata[157:127];
          area_nxt  = in_tdata[188:158];
          itan_nxt  = in_tdata[219:189];
          mtan_nxt  = in_tdata[250:220];
          last_nxt  = in_tlast;
        end
      end
      fpw_pkg::S_SQX: prod_nxt = 64'(dx_r) * 64'(dx_r);
      fpw_pkg::S_SQY: begin
        sqv_nxt   = prod_r + 64'(dy_r) * 64'(dy_r);
        sqr_nxt   = 64'd0;
        sqbit_nxt = 64'd1 << 62;
        step_nxt  = 6'd0;
      end
      fpw_pkg::S_ROOT: begin
        if (sq_ge) begin
          sqv_nxt = sqv_r - sq_test;
          sqr_nxt = (sqr_r >> 1) + sqbit_r;
        end else begin
          sqr_nxt = sqr_r >> 1;
        end
        sqbit_nxt = sqbit_r >> 2;
        step_nxt  = step_r + 6'd1;
      end
      fpw_pkg::S_RUN: prod_nxt = (64'(sqr_r[31:0]) * 64'(cell_r)) >> 16;
      fpw_pkg::S_RUNFIX: begin
        den_nxt  = (prod_r == 64'd0) ? fpw_pkg::RUN_MIN : prod_r;
        quo_nxt  = {16'd0, rise_mag, 16'd0};
        rem_nxt  = 65'd0;
        step_nxt = 6'd0;
      end
      fpw_pkg::S_SLOPE: begin
        if (rise_r[31]) begin
          slope_nxt = (quo_r > 64'h8000_0000) ? 32'h8000_0000 : (~quo_r[31:0] + 32'd1);
        end else begin
          slope_nxt = (quo_r > 64'(fpw_pkg::SAT31)) ? {1'b0, fpw_pkg::SAT31} : quo_r[31:0];
        end
        wgt_nxt = 31'd0;
      end
      fpw_pkg::S_PMUL: prod_nxt = (64'(perim_r) * 64'(mult_r)) >> 16;
      // Hold the low partial product; park the high part of p in the square root
      // register, free at this point.
      fpw_pkg::S_PSLO: begin
        prod_nxt = 64'(prod_r[31:0]) * 64'(slope_r[30:0]);
        sqr_nxt  = 64'(prod_r[45:32]);
      end
      fpw_pkg::S_PSHI: begin
        // Saturate when (p*s) >> 16 reaches 2^46, which also covers 64-bit overflow.
        if (ps_full[77:62] != 16'd0) begin
          wgt_nxt = fpw_pkg::SAT31;
        end else begin
          quo_nxt  = {2'd0, ps_full[61:16], 16'd0};
          den_nxt  = (cell_r == 31'd0) ? 64'd1 : 64'(cell_r);
          rem_nxt  = 65'd0;
          step_nxt = 6'd0;
        end
      end
      fpw_pkg::S_WEIGHT: begin
        wgt_nxt = (quo_r > 64'(fpw_pkg::SAT31)) ? fpw_pkg::SAT31 : quo_r[30:0];
      end
      fpw_pkg::S_SWMUL: begin
        prod_nxt = 64'(slope_r[30:0]) * 64'(wgt_r);
        sws_nxt  = (sws_r > fpw_pkg::U64_MAX - (64'(slope_r[30:0]) * 64'(wgt_r)))
                   ? fpw_pkg::U64_MAX : sws_r + 64'(slope_r[30:0]) * 64'(wgt_r);
      end
      fpw_pkg::S_STORE: begin
        ws_nxt  = ws_r + 40'(wgt_r);
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      fpw_pkg::S_FIN: begin
        pslope_nxt = 31'd0;
        quo_nxt    = sws_r;
        den_nxt    = 64'(ws_r);
        rem_nxt    = 65'd0;
        step_nxt   = 6'd0;
      end
      fpw_pkg::S_PSET: begin
        if (ws_r != 40'd0) begin
          pslope_nxt = (quo_r > 64'(fpw_pkg::SAT31)) ? fpw_pkg::SAT31 : quo_r[30:0];
        end
        total_nxt = (ws_r > 40'(fpw_pkg::SAT31)) ? fpw_pkg::SAT31 : ws_r[30:0];
        macc_nxt  = 64'(mult_r);
        mstep_nxt = 2'd0;
        k_nxt     = '0;
      end
      fpw_pkg::S_MLO: prod_nxt = 64'(macc_r[31:0]) * 64'(mul_b);
      fpw_pkg::S_MHI: begin
        macc_nxt  = m_res;
        mstep_nxt = mstep_r + 2'd1;
        total_nxt = (m_res > 64'(fpw_pkg::SAT31)) ? fpw_pkg::SAT31 : m_res[30:0];
      end
      fpw_pkg::S_RDW: begin
        slope_nxt = ram_q[62:31];
        wgt_nxt   = ram_q[30:0];
        quo_nxt   = (ws_r != 40'd0) ? {17'd0, ram_q[30:0], 16'd0} : 64'd0;
        den_nxt   = 64'(ws_r);
        rem_nxt   = 65'd0;
        step_nxt  = 6'd0;
      end
      fpw_pkg::S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = emit_last;
          out_num_nxt    = 4'(k_r);
          out_slope_nxt  = slope_r;
          out_frac_nxt   = quo_r[16:0];
          out_pslope_nxt = {1'b0, pslope_r};
          out_total_nxt  = total_r;
          if (emit_last) begin
            cnt_nxt = '0;
            ws_nxt  = 40'd0;
            sws_nxt = 64'd0;
          end else begin
            k_nxt = k_r + ADDR_W'(1);
          end
        end
      end
      default: begin
        mstep_nxt = mstep_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpw_pkg::S_IDLE;
      cell_r      <= 31'h0001_0000;
      mode_r      <= fpw_pkg::MODE_SUM;
      cnt_r       <= '0;
      ws_r        <= 40'd0;
      sws_r       <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cell_r      <= cell_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      ws_r        <= ws_nxt;
      sws_r       <= sws_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;         dy_r <= dy_nxt;         rise_r <= rise_nxt;
    perim_r <= perim_nxt;   mult_r <= mult_nxt;     area_r <= area_nxt;
    itan_r <= itan_nxt;     mtan_r <= mtan_nxt;     last_r <= last_nxt;
    prod_r <= prod_nxt;
    sqv_r <= sqv_nxt;       sqr_r <= sqr_nxt;       sqbit_r <= sqbit_nxt;
    rem_r <= rem_nxt;       quo_r <= quo_nxt;       den_r <= den_nxt;
    step_r <= step_nxt;
    slope_r <= slope_nxt;   wgt_r <= wgt_nxt;
    pslope_r <= pslope_nxt; total_r <= total_nxt;
    macc_r <= macc_nxt;     mstep_r <= mstep_nxt;   k_r <= k_nxt;
    out_last_r <= out_last_nxt;     out_num_r <= out_num_nxt;
    out_slope_r <= out_slope_nxt;   out_frac_r <= out_frac_nxt;
    out_pslope_r <= out_pslope_nxt; out_total_r <= out_total_nxt;
  end

  assign in_tready  = state_r == fpw_pkg::S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_total_r, out_pslope_r, out_frac_r, out_slope_r, out_num_r};

`ifndef NO_ASSERTIONS
  a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpw_pkg::S_STORE) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("neighbour count did not advance on store");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == fpw_pkg::S_EMIT))
    else $error("result appeared outside emission");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && cnt_full && !in_tlast) |=>
      (state_r == fpw_pkg::S_IDLE && cnt_r == CNT_W'(MAX_NEIGHBOURS)))
    else $error("request beyond capacity was not dropped");
`endif

endmodule
`default_nettype wire

// File: dv/fpw_checker.sv
// Flow weighting checker: watches the request, result and register ports, predicts and compares.
`default_nettype none
module fpw_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  // delta_x, delta_y, rise, perimeter, patch_mult, patch_area, internal_tan, max_tan
  input  wire logic [255:0] in_tdata,
  input  wire logic         in_tlast,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  // neighbour_number, neighbour_slope, weight_fraction, patch_slope, total_weight
  input  wire logic [119:0] out_tdata,
  input  wire logic         out_tlast,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [30:0]  cfg_data,
  output int                errors,
  output int                pending
);

  localparam int NB_MAX = 16;
  localparam longint unsigned MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned LIM31 = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [3:0]  num;
    logic [31:0] slope;
    logic [16:0] frac;
    logic [31:0] pslope;
    logic [30:0] total;
    logic        last;
  } flow_result_t;

  flow_result_t expected_results[$];

  logic [30:0]     cell_len;
  logic [1:0]      mode;
  longint          nb_slope[NB_MAX];
  longint unsigned nb_weight[NB_MAX];
  int              nb_count;
  longint unsigned wsum;
  longint unsigned swsum;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, cand;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  function automatic longint unsigned qmul_sat(longint unsigned a, longint unsigned b);
    if (a == 0 || b == 0) return 0;
    if (a == MAX64 || a > MAX64 / b) return MAX64;
    return (a * b) >> 16;
  endfunction

  function automatic longint unsigned abs32(logic [31:0] v);
    longint sv;
    sv = longint'(signed'(v));
    return sv < 0 ? longint'(-sv) : sv;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("error: %s got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic predict_neighbour(logic [255:0] d, logic last);
    longint unsigned dx, dy, run, q, w, p, t, s, cdiv, mult, total, pslope, frac;
    longint rise, slope;
    flow_result_t r;
    dx   = abs32(d[31:0]);
    dy   = abs32(d[63:32]);
    rise = longint'(signed'(d[95:64]));
    mult = 64'(d[157:127]);
    if (nb_count < NB_MAX) begin
      run  = (root_floor(dx * dx + dy * dy) * 64'(cell_len)) >> 16;
      cdiv = (cell_len != 0) ? 64'(cell_len) : 64'd1;
      if (run == 0) run = fpw_pkg::RUN_MIN;
      q = (abs32(d[95:64]) << 16) / run;
      if (rise < 0) slope = (q > 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(q);
      else slope = (q > LIM31) ? longint'(LIM31) : longint'(q);
      w = 0;
      if (slope > 0) begin
        s = slope;
        p = (64'(d[126:96]) * mult) >> 16;
        if (p != 0 && p > MAX64 / s) w = LIM31;
        else begin
          t = (p * s) >> 16;
          if (t >= (64'd1 << 46)) w = LIM31;
          else begin
            w = (t << 16) / cdiv;
            if (w > LIM31) w = LIM31;
          end
        end
        if (w != 0) swsum = (swsum > MAX64 - s * w) ? MAX64 : swsum + s * w;
      end
      nb_slope[nb_count]  = slope;
      nb_weight[nb_count] = w;
      wsum += w;
      nb_count++;
    end
    if (!last) return;
    pslope = 0;
    if (wsum != 0) begin
      pslope = swsum / wsum;
      if (pslope > LIM31) pslope = LIM31;
    end
    if (mode == fpw_pkg::MODE_INTERNAL || mode == fpw_pkg::MODE_MAXIMUM) begin
      total = qmul_sat(mult, mode == fpw_pkg::MODE_INTERNAL ? 64'(d[219:189])
                                                            : 64'(d[250:220]));
      total = qmul_sat(total, 64'(d[188:158]));
      total = qmul_sat(total, 64'(cell_len));
      total = qmul_sat(total, 64'(cell_len));
    end else begin
      total = wsum;
    end
    if (total > LIM31) total = LIM31;
    for (int k = 0; k < nb_count; k++) begin
      frac = (wsum != 0) ? (nb_weight[k] << 16) / wsum : 0;
      r.num    = k[3:0];
      r.slope  = nb_slope[k][31:0];
      r.frac   = frac[16:0];
      r.pslope = pslope[31:0];
      r.total  = total[30:0];
      r.last   = (k + 1 == nb_count);
      expected_results.push_back(r);
    end
    nb_count = 0;
    wsum     = 0;
    swsum    = 0;
  endtask

  always @(posedge clk) begin
    flow_result_t want;
    if (!rst_n) begin
      cell_len = 31'd65536;
      mode     = fpw_pkg::MODE_SUM;
      nb_count = 0;
      wsum     = 0;
      swsum    = 0;
      expected_results.delete();
      errors   = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == fpw_pkg::REG_CELL_SIZE) cell_len = cfg_data;
        else mode = cfg_data[1:0];
      end
      if (in_tvalid && in_tready) predict_neighbour(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", out_tdata[63:0], 0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[3:0] != want.num) report("neighbour_number", out_tdata[3:0], want.num);
          if (out_tdata[35:4] != want.slope)
            report("neighbour_slope", out_tdata[35:4], want.slope);
          if (out_tdata[52:36] != want.frac)
            report("weight_fraction", out_tdata[52:36], want.frac);
          if (out_tdata[84:53] != want.pslope)
            report("patch_slope", out_tdata[84:53], want.pslope);
          if (out_tdata[115:85] != want.total)
            report("total_weight", out_tdata[115:85], want.total);
          if (out_tlast != want.last) report("last_result", out_tlast, want.last);
        end
      end
    end
    pending = expected_results.size();
  end
endmodule
`default_nettype wire

// File: dv/tb_flow_partition_weights.sv
// Testbench top: drives neighbour requests, register writes and result stalls, gives the verdict.
`default_nettype none
module tb_flow_partition_weights;

  localparam int CYCLE_LIMIT = 800000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_index = fpw_pkg::REG_CELL_SIZE;
  logic [30:0]  cfg_data = '0;
  int           errors;
  int           pending;
  int           cycles = 0;
  int           burst_left = 0;
  int           stall_left = 0;
  int           run_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  flow_partition_weights dut (.*);

  fpw_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("flow_partition_weights: mismatch");
      $finish;
    end
  end

  // Receiver: stretches of full readiness alternate with random stalls.
  always @(negedge clk) begin
    if (run_left > 0) begin
      run_left <= run_left - 1;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      run_left   <= $urandom_range(0, 40);
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      out_tready <= $urandom_range(0, 1);
    end
  end

  task automatic send(logic [31:0] dx, logic [31:0] dy, logic [31:0] rise,
                      logic [30:0] perim, logic [30:0] mult, logic [30:0] area,
                      logic [30:0] itan, logic [30:0] mtan, logic last);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_tdata  = {5'b0, mtan, itan, area, mult, perim, rise, dy, dx};
    in_tlast  = last;
    in_tvalid = 1'b1;
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [30:0] value);
    in_tvalid = 1'b0;
    wait (pending == 0);
    repeat (300) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_signed(int span);
    if ($urandom_range(0, 6) == 0) return $urandom;
    return $urandom_range(0, 1) ? 32'($urandom_range(0, span)) : -32'($urandom_range(0, span));
  endfunction

  function automatic logic [30:0] pick_unsigned(int span);
    if ($urandom_range(0, 6) == 0) return 31'($urandom);
    return 31'($urandom_range(0, span));
  endfunction

  task automatic random_patch(int n);
    for (int i = 0; i < n; i++)
      send(pick_signed(4 << 16), pick_signed(4 << 16),
           ($urandom_range(0, 4) == 0) ? pick_signed(40 << 16) : $urandom_range(0, 40 << 16),
           pick_unsigned(3 << 16), pick_unsigned(2 << 16), pick_unsigned(60 << 16),
           pick_unsigned(1 << 16), pick_unsigned(2 << 16), i == n - 1);
  endtask

  initial begin
    int sent;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero run, extremes, negative and zero rise, zero weight sum.
    send(32'h0, 32'h0, 32'h0001_0000, 31'h1_0000, 31'h1_0000, 31'h4_0000,
         31'h8000, 31'h1_0000, 1'b0);
    send(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, fpw_pkg::SAT31, fpw_pkg::SAT31,
         fpw_pkg::SAT31, fpw_pkg::SAT31, fpw_pkg::SAT31, 1'b0);
    send(32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000, fpw_pkg::SAT31, fpw_pkg::SAT31,
         31'd0, 31'd0, 31'd0, 1'b0);
    send(32'h0001_0000, 32'hFFFF_0000, 32'h0, 31'h2_0000, 31'h1_0000,
         31'd0, 31'd0, 31'd0, 1'b1);
    send(32'h0001_0000, 32'h0, 32'hFFFF_0000, 31'h1_0000, 31'h1_0000,
         31'd0, 31'd0, 31'd0, 1'b1);
    send(32'h0, 32'h0, 32'h7FFF_FFFF, 31'd0, fpw_pkg::SAT31, 31'd0, 31'd0, 31'd0, 1'b1);

    write_reg(fpw_pkg::REG_SLOPE_MODE, 31'(fpw_pkg::MODE_INTERNAL));
    write_reg(fpw_pkg::REG_CELL_SIZE, 31'd0);
    send(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 31'h1_0000, 31'h2_0000,
         31'h10_0000, 31'h8000, 31'h2_0000, 1'b1);
    send(32'h0, 32'h0, 32'h0000_0001, fpw_pkg::SAT31, fpw_pkg::SAT31, fpw_pkg::SAT31,
         fpw_pkg::SAT31, fpw_pkg::SAT31, 1'b1);

    write_reg(fpw_pkg::REG_SLOPE_MODE, 31'(fpw_pkg::MODE_MAXIMUM));
    write_reg(fpw_pkg::REG_CELL_SIZE, fpw_pkg::SAT31);
    send(32'h0001_0000, 32'h0, 32'h7FFF_FFFF, fpw_pkg::SAT31, fpw_pkg::SAT31,
         fpw_pkg::SAT31, fpw_pkg::SAT31, fpw_pkg::SAT31, 1'b0);
    send(32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 31'h1_0000, 31'h1_0000,
         31'h4_0000, 31'h1_0000, 31'h2_0000, 1'b1);

    write_reg(fpw_pkg::REG_SLOPE_MODE, 31'(fpw_pkg::MODE_SPARE));
    write_reg(fpw_pkg::REG_CELL_SIZE, 31'd1);
    send(32'h0001_0000, 32'h0, 32'h0001_0000, 31'h1_0000, 31'h1_0000,
         31'd0, 31'd0, 31'd0, 1'b0);
    send(32'h0, 32'h0003_0000, 32'hFFFE_0000, 31'h1_0000, 31'h1_0000,
         31'd0, 31'd0, 31'd0, 1'b1);

    // Random phases over several register settings.
    sent = 12;
    for (int phase = 0; sent < 280; phase++) begin
      if (phase % 3 == 0) begin
        write_reg(fpw_pkg::REG_SLOPE_MODE, 31'($urandom_range(0, 3)));
        write_reg(fpw_pkg::REG_CELL_SIZE, ($urandom_range(0, 2) == 0) ? 31'($urandom)
                                                             : 31'($urandom_range(1, 4 << 16)));
      end
      if (phase == 5) begin
        // Overflow the neighbour store: the extra requests are dropped.
        random_patch(19);
        sent += 19;
      end else if (phase == 9) begin
        random_patch(16);
        sent += 16;
      end else begin
        int n;
        n = $urandom_range(1, 6);
        random_patch(n);
        sent += n;
      end
      if (phase % 7 == 3) begin
        in_tvalid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
    end

    in_tvalid = 1'b0;
    wait (pending == 0);
    repeat (400) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("flow_partition_weights: match");
    else
      $display("flow_partition_weights: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
